// ===== design/feedback_echo_delay_line_top_defines.svh =====
// Assertion macros shared by the echo delay line modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef FEEDBACK_ECHO_DELAY_LINE_TOP_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_LINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FEDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FEDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fedl_pkg.sv =====
// Package for the feedback echo delay line: sample widths, mix constants
// and the reset value of the delay register. No dependencies.
package fedl_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned SUM_W    = 20;
	localparam int unsigned MAG_W    = 19;

	// ceil(2^22 / 10); exact for magnitudes below 699050.
	localparam int unsigned RECIP_SHIFT = 22;
	localparam logic [MAG_W-1:0] MIX_RECIP = 19'd419431;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd44100;

endpackage

// ===== design/fedl_mix.sv =====
// Two-stage mixer: weighted sum 7*dry + 3*wet, then truncating division by ten
// through a reciprocal multiply. Depends on fedl_pkg.
module fedl_mix (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0]  dry,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0]  wet,
	output logic signed [fedl_pkg::SAMPLE_W-1:0]  mix
);

	localparam int unsigned PROD_W = 2 * fedl_pkg::MAG_W;

	logic signed [fedl_pkg::SUM_W-1:0] dry_x;
	logic signed [fedl_pkg::SUM_W-1:0] wet_x;
	logic signed [fedl_pkg::SUM_W-1:0] sum;
	logic signed [fedl_pkg::SUM_W-1:0] sum_s2;
	logic        [fedl_pkg::SUM_W-1:0] neg_sum;
	logic        [fedl_pkg::MAG_W-1:0] mag;
	logic        [PROD_W-1:0]          prod;
	logic        [fedl_pkg::SAMPLE_W-1:0] quo;

	assign dry_x = {{(fedl_pkg::SUM_W - fedl_pkg::SAMPLE_W){dry[fedl_pkg::SAMPLE_W-1]}}, dry};
	assign wet_x = {{(fedl_pkg::SUM_W - fedl_pkg::SAMPLE_W){wet[fedl_pkg::SAMPLE_W-1]}}, wet};
	assign sum   = (dry_x <<< 3) - dry_x + (wet_x <<< 1) + wet_x;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum;
		end
	end

	// The sum stays within +/-327680, so its magnitude fits in 19 bits.
	assign neg_sum = -sum_s2;
	assign mag     = sum_s2[fedl_pkg::SUM_W-1] ? neg_sum[fedl_pkg::MAG_W-1:0]
	                                           : sum_s2[fedl_pkg::MAG_W-1:0];
	assign prod    = PROD_W'(mag) * PROD_W'(fedl_pkg::MIX_RECIP);
	assign quo     = prod[fedl_pkg::RECIP_SHIFT +: fedl_pkg::SAMPLE_W];
	assign mix     = sum_s2[fedl_pkg::SUM_W-1] ? -quo : quo;

	// Reset is only used to qualify the assertions below.
	`include "feedback_echo_delay_line_top_defines.svh"

	`FEDL_ASSERT_NOW(a_mix_sign, (sum_s2 != '0), (mix == '0) || (mix[fedl_pkg::SAMPLE_W-1] == sum_s2[fedl_pkg::SUM_W-1]), "mix sign differs from sum sign")
	`FEDL_ASSERT_NOW(a_mix_zero, (sum_s2 == '0), (mix == '0), "zero sum gives non-zero mix")
	`FEDL_ASSERT_NOW(a_mag_range, !$isunknown(sum_s2), (mag <= 19'd327680), "mix magnitude out of range")

endmodule

// ===== design/feedback_echo_delay_line_top.sv =====
// Top level of the feedback echo delay line: echo store, pointers, hazard
// interlock and output register. Depends on fedl_pkg and fedl_mix.
//
//  Channel   Dir  Signals                          Payload
//  s_axis    in   tvalid tready tdata[15:0]        in_sample (signed)
//  m_axis    out  tvalid tready tdata[15:0]        out_sample (signed)
//  cfg       in   cfg_we cfg_wdata[15:0]           delay_samples
//
// One sample per cycle when not stalled; a result is registered in stage one, in
// the mixer and at the output. When the read address hits one of the two samples
// still being mixed (clamped delay of one or two), input waits for its write-back.
// No clearing pass after reset: a fill pointer makes never-written entries read
// as zero. A stalled output freezes the whole pipeline, including the store.
module feedback_echo_delay_line_top #(
	parameter int unsigned DEPTH = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,   // [15:0] in_sample
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [15:0]                      m_axis_tdata,   // [15:0] out_sample
	input  logic                             cfg_we,
	input  logic [fedl_pkg::DELAY_W-1:0]     cfg_wdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = (AW > fedl_pkg::DELAY_W) ? AW : fedl_pkg::DELAY_W;
	localparam logic [CW-1:0] DMAX = CW'(DEPTH - 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

	logic [fedl_pkg::SAMPLE_W-1:0] echo_mem_q [0:DEPTH-1];

	logic [fedl_pkg::DELAY_W-1:0] delay_q;
	logic [AW-1:0]                wp_q;
	logic                         wrapped_q;

	logic [CW-1:0]  delay_x;
	logic [CW-1:0]  delay_cl;
	logic [AW:0]    diff;
	logic [AW-1:0]  rd_addr;
	logic           hazard;
	logic           en;
	logic           acc;

	logic                                vld_s1;
	logic [AW-1:0]                       wp_s1;
	logic                                fill_s1;
	logic signed [fedl_pkg::SAMPLE_W-1:0] dry_s1;
	logic        [fedl_pkg::SAMPLE_W-1:0] rdata_s1;
	logic signed [fedl_pkg::SAMPLE_W-1:0] wet;

	logic                                vld_s2;
	logic [AW-1:0]                       wp_s2;
	logic signed [fedl_pkg::SAMPLE_W-1:0] mix;

	logic                          out_valid_q;
	logic [fedl_pkg::SAMPLE_W-1:0] out_data_q;

	// Read address: write pointer minus the clamped delay, modulo DEPTH.
	assign delay_x  = CW'(delay_q);
	assign delay_cl = (delay_x > DMAX) ? DMAX : delay_x;
	assign diff     = {1'b0, wp_q} - {1'b0, delay_cl[AW-1:0]};
	assign rd_addr  = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];

	// An entry still owed a write-back by a sample in flight must not be read yet.
	assign hazard = (vld_s1 && (wp_s1 == rd_addr)) || (vld_s2 && (wp_s2 == rd_addr));
	assign en     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en && !hazard;
	assign acc    = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= fedl_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (acc) begin
			if (wp_q == PTR_LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// Echo store: one read on transfer, one write-back from the second stage.
	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= echo_mem_q[rd_addr];
		end
		if (en && vld_s2) begin
			echo_mem_q[wp_s2] <= mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= acc;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			wp_s1   <= wp_q;
			dry_s1  <= s_axis_tdata;
			fill_s1 <= wrapped_q || (rd_addr < wp_q);
		end
		if (en) begin
			wp_s2 <= wp_s1;
		end
		if (en && vld_s2) begin
			out_data_q <= mix;
		end
	end

	assign wet = fill_s1 ? rdata_s1 : '0;

	fedl_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.dry    (dry_s1),
		.wet    (wet),
		.mix    (mix)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`include "feedback_echo_delay_line_top_defines.svh"

	`FEDL_ASSERT_NOW(a_no_raw, acc, !(vld_s2 && (wp_s2 == rd_addr)) && !(vld_s1 && (wp_s1 == rd_addr)), "read of an entry with a pending write-back")
	`FEDL_ASSERT_NOW(a_flight_distinct, vld_s1 && vld_s2, wp_s1 != wp_s2, "two samples in flight share a pointer")
	`FEDL_ASSERT_NEXT(a_wrap_sticky, wrapped_q, wrapped_q, "fill state cleared after wrapping")
	`FEDL_ASSERT_NEXT(a_stall_freeze, vld_s2 && !en, vld_s2 && $stable(wp_s2), "pipeline moved during an output stall")

endmodule
